// ===== design/serial_boot_loader_command_engine_unit_assert.svh =====
// Assertion macros shared by the serial boot loader command engine RTL.
// Every macro assumes a clock named clk and an active low reset named rst_n.
`ifndef SERIAL_BOOT_LOADER_COMMAND_ENGINE_UNIT_ASSERT_SVH
`define SERIAL_BOOT_LOADER_COMMAND_ENGINE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBLCE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBLCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sblce_pkg.sv =====
// Package of the serial boot loader command engine: result types, codes and CRC step.
// No dependencies; every RTL file of the engine refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sblce_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_SEND   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_BAUD   = 3'd2;
  localparam logic [2:0] KIND_WINDOW = 3'd3;
  localparam logic [2:0] KIND_JUMP   = 3'd4;

  // Status bytes sent back to the host.
  localparam logic [7:0] ST_FAIL = 8'h1C;
  localparam logic [7:0] ST_PONG = 8'h52;
  localparam logic [7:0] ST_OK   = 8'hC1;

  // Command bytes.
  localparam logic [7:0] CMD_PROBE  = 8'h41;
  localparam logic [7:0] CMD_EXTRAM = 8'h45;
  localparam logic [7:0] CMD_JUMP   = 8'h47;
  localparam logic [7:0] CMD_SPEED  = 8'h48;
  localparam logic [7:0] CMD_LZ4    = 8'h4C;
  localparam logic [7:0] CMD_WRITE  = 8'h57;

  // External RAM window limits.
  localparam logic [31:0] RAM_MIN_SIZE = 32'h0000_1000;
  localparam logic [31:0] RAM_MAX_SIZE = 32'h0800_0000;
  localparam int RAM_MIN_LOG2  = 12;
  localparam int RAM_MAX_LOG2  = 27;
  localparam int RAM_MASK_BASE = 27;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Default depth of the result queue.
  localparam int RESQ_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [31:0] target_address;
    logic [7:0]  write_data;
    logic [31:0] baud_value;
    logic [3:0]  window_mask;
    logic        last;
  } res_t;

  // Up to two results produced by one received byte, r0 first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] tx,
                                  input logic [31:0] addr, input logic [7:0] data,
                                  input logic [31:0] baud, input logic [3:0] mask);
    res_t r;
    r.kind           = kind;
    r.tx_byte        = tx;
    r.target_address = addr;
    r.write_data     = data;
    r.baud_value     = baud;
    r.window_mask    = mask;
    r.last           = 1'b0;
    return r;
  endfunction

  // Reflected CRC-32, one byte per call.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/sblce_core.sv =====
// Command parser of the serial boot loader engine: phase, field shifter, CRC, results.
// Depends on sblce_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module sblce_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           go,
  input  wire logic [7:0]     rx_byte,
  output sblce_pkg::push_t    push
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_WR_ADDR  = 4'd1;
  localparam logic [3:0] PH_WR_SIZE  = 4'd2;
  localparam logic [3:0] PH_WR_DATA  = 4'd3;
  localparam logic [3:0] PH_WR_CRC   = 4'd4;
  localparam logic [3:0] PH_EX_ADDR  = 4'd5;
  localparam logic [3:0] PH_EX_SIZE  = 4'd6;
  localparam logic [3:0] PH_SP_BAUD  = 4'd7;
  localparam logic [3:0] PH_SP_WAIT  = 4'd8;
  localparam logic [3:0] PH_GO_ADDR  = 4'd9;
  localparam logic [3:0] PH_LZ_ADDR  = 4'd10;
  localparam logic [3:0] PH_LZ_CSIZE = 4'd11;
  localparam logic [3:0] PH_LZ_OSIZE = 4'd12;
  localparam logic [3:0] PH_LZ_DATA  = 4'd13;
  localparam logic [3:0] PH_LZ_CRC   = 4'd14;

  localparam logic [1:0] FCNT_LAST = 2'd3;

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  fcnt_r, fcnt_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] done_r, done_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] gcrc_r, gcrc_nxt;

  logic        take_last;
  logic [1:0]  fcnt_inc;
  logic [31:0] addr_sh, len_sh, gcrc_sh;
  logic [31:0] size_m1;
  logic        ram_bad;
  logic [3:0]  win_mask;
  logic [31:0] done_inc;
  logic [31:0] crc_upd;
  sblce_pkg::res_t r0, r1;
  logic [1:0]  n;

  // Little-endian fields enter from the top byte.
  assign addr_sh   = {rx_byte, addr_r[31:8]};
  assign len_sh    = {rx_byte, len_r[31:8]};
  assign gcrc_sh   = {rx_byte, gcrc_r[31:8]};
  assign take_last = (fcnt_r == FCNT_LAST);
  assign fcnt_inc  = take_last ? 2'd0 : fcnt_r + 2'd1;
  assign done_inc  = done_r + 32'd1;
  assign crc_upd   = sblce_pkg::crc_byte(crc_r, rx_byte);
  assign size_m1   = len_sh - 32'd1;
  assign ram_bad   = (len_sh < sblce_pkg::RAM_MIN_SIZE) || (len_sh > sblce_pkg::RAM_MAX_SIZE) ||
                     ((len_sh & size_m1) != 32'd0) || ((addr_r & size_m1) != 32'd0);

  // The size is a single set bit when the window is accepted.
  always_comb begin
    win_mask = 4'd0;
    for (int i = sblce_pkg::RAM_MIN_LOG2; i <= sblce_pkg::RAM_MAX_LOG2; i++) begin
      if (len_sh[i]) win_mask = 4'(sblce_pkg::RAM_MASK_BASE - i);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    fcnt_nxt  = fcnt_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    done_nxt  = done_r;
    crc_nxt   = crc_r;
    gcrc_nxt  = gcrc_r;
    n         = 2'd0;
    r0        = '0;
    r1        = '0;
    unique case (phase_r)
      PH_IDLE: begin
        fcnt_nxt = 2'd0;
        case (rx_byte)
          sblce_pkg::CMD_PROBE: begin
            n  = 2'd1;
            r0 = sblce_pkg::mk_res(sblce_pkg::KIND_SEND, sblce_pkg::ST_PONG,
                                   '0, '0, '0, '0);
          end
          sblce_pkg::CMD_EXTRAM: phase_nxt = PH_EX_ADDR;
          sblce_pkg::CMD_JUMP:   phase_nxt = PH_GO_ADDR;
          sblce_pkg::CMD_SPEED:  phase_nxt = PH_SP_BAUD;
          sblce_pkg::CMD_LZ4:    phase_nxt = PH_LZ_ADDR;
          sblce_pkg::CMD_WRITE:  phase_nxt = PH_WR_ADDR;
          default: ;
        endcase
      end
      PH_WR_ADDR, PH_EX_ADDR, PH_LZ_ADDR: begin
        addr_nxt = addr_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) begin
          phase_nxt = (phase_r == PH_WR_ADDR) ? PH_WR_SIZE :
                      (phase_r == PH_EX_ADDR) ? PH_EX_SIZE : PH_LZ_CSIZE;
        end
      end
      PH_WR_SIZE: begin
        len_nxt  = len_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) begin
          done_nxt  = 32'd0;
          crc_nxt   = sblce_pkg::CRC_INIT;
          phase_nxt = (len_sh == 32'd0) ? PH_WR_CRC : PH_WR_DATA;
        end
      end
      PH_WR_DATA: begin
        n  = 2'd1;
        r0 = sblce_pkg::mk_res(sblce_pkg::KIND_WRITE, '0, addr_r + done_r, rx_byte,
                               '0, '0);
        crc_nxt  = crc_upd;
        done_nxt = done_inc;
        if (done_inc >= len_r) phase_nxt = PH_WR_CRC;
      end
      PH_WR_CRC: begin
        gcrc_nxt = gcrc_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) begin
          n  = 2'd1;
          r0 = sblce_pkg::mk_res(sblce_pkg::KIND_SEND,
                                 (gcrc_sh == ~crc_r) ? sblce_pkg::ST_OK : sblce_pkg::ST_FAIL,
                                 '0, '0, '0, '0);
          phase_nxt = PH_IDLE;
        end
      end
      PH_EX_SIZE: begin
        len_nxt  = len_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) begin
          if (ram_bad) begin
            n  = 2'd1;
            r0 = sblce_pkg::mk_res(sblce_pkg::KIND_SEND, sblce_pkg::ST_FAIL,
                                   '0, '0, '0, '0);
          end else begin
            n  = 2'd2;
            r0 = sblce_pkg::mk_res(sblce_pkg::KIND_WINDOW, '0, addr_r, '0, '0, win_mask);
            r1 = sblce_pkg::mk_res(sblce_pkg::KIND_SEND, sblce_pkg::ST_OK,
                                   '0, '0, '0, '0);
          end
          phase_nxt = PH_IDLE;
        end
      end
      PH_SP_BAUD: begin
        len_nxt  = len_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) begin
          n  = 2'd1;
          r0 = sblce_pkg::mk_res(sblce_pkg::KIND_BAUD, '0, '0, '0, len_sh, '0);
          phase_nxt = PH_SP_WAIT;
        end
      end
      PH_SP_WAIT: begin
        if (rx_byte == sblce_pkg::CMD_PROBE) begin
          n  = 2'd1;
          r0 = sblce_pkg::mk_res(sblce_pkg::KIND_SEND, sblce_pkg::ST_PONG,
                                 '0, '0, '0, '0);
          phase_nxt = PH_IDLE;
        end
      end
      PH_GO_ADDR: begin
        addr_nxt = addr_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) begin
          n  = 2'd2;
          r0 = sblce_pkg::mk_res(sblce_pkg::KIND_SEND, sblce_pkg::ST_OK, '0, '0, '0, '0);
          r1 = sblce_pkg::mk_res(sblce_pkg::KIND_JUMP, '0, addr_sh, '0, '0, '0);
          phase_nxt = PH_IDLE;
        end
      end
      PH_LZ_CSIZE: begin
        len_nxt  = len_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) phase_nxt = PH_LZ_OSIZE;
      end
      PH_LZ_OSIZE: begin
        // The output size lands in the CRC holding register and is never used.
        gcrc_nxt = gcrc_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) begin
          done_nxt  = 32'd0;
          phase_nxt = (len_r == 32'd0) ? PH_LZ_CRC : PH_LZ_DATA;
        end
      end
      PH_LZ_DATA: begin
        done_nxt = done_inc;
        if (done_inc >= len_r) phase_nxt = PH_LZ_CRC;
      end
      PH_LZ_CRC: begin
        gcrc_nxt = gcrc_sh;
        fcnt_nxt = fcnt_inc;
        if (take_last) begin
          n  = 2'd1;
          r0 = sblce_pkg::mk_res(sblce_pkg::KIND_SEND, sblce_pkg::ST_FAIL,
                                 '0, '0, '0, '0);
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        fcnt_nxt  = 2'd0;
        phase_nxt = PH_IDLE;
      end
    endcase
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  always_comb begin
    push.cnt = go ? n : 2'd0;
    push.r0  = r0;
    push.r1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fcnt_r  <= 2'd0;
      addr_r  <= 32'd0;
      len_r   <= 32'd0;
      done_r  <= 32'd0;
      crc_r   <= sblce_pkg::CRC_INIT;
      gcrc_r  <= 32'd0;
    end else if (go) begin
      phase_r <= phase_nxt;
      fcnt_r  <= fcnt_nxt;
      addr_r  <= addr_nxt;
      len_r   <= len_nxt;
      done_r  <= done_nxt;
      crc_r   <= crc_nxt;
      gcrc_r  <= gcrc_nxt;
    end
  end

`include "serial_boot_loader_command_engine_unit_assert.svh"

  `SBLCE_ASSERT_SAME(a_pair_order, push.cnt == 2'd2, push.r1.last && !push.r0.last, "pair last flag misplaced")
  `SBLCE_ASSERT_SAME(a_write_phase, push.cnt != 2'd0 && push.r0.kind == sblce_pkg::KIND_WRITE, phase_r == PH_WR_DATA, "memory write outside data phase")
  `SBLCE_ASSERT_NEXT(a_field_restart, go && phase_r == PH_IDLE, fcnt_r == 2'd0, "field counter not cleared by command")

endmodule

`default_nettype wire

// ===== design/sblce_resq.sv =====
// Result queue of the serial boot loader engine: takes up to two results per cycle, gives one.
// Depends on sblce_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

module sblce_resq #(
  parameter int DEPTH = sblce_pkg::RESQ_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  sblce_pkg::push_t      push,
  input  wire logic             pop,
  output logic                  room,
  output logic                  head_valid,
  output sblce_pkg::res_t       head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sblce_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] tail1, tail2;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign tail1 = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + PW'(1);
  assign tail2 = (tail1 == PW'(DEPTH - 1)) ? '0 : tail1 + PW'(1);

  assign head_valid = (count_r != '0);
  assign head       = mem_r[head_r];
  assign do_pop     = pop && head_valid;
  // Room for a full pair, so the parser never has to split one byte's results.
  assign room       = (count_r <= CW'(DEPTH - 2));

  always_comb begin
    tail_nxt = tail_r;
    case (push.cnt)
      2'd1:    tail_nxt = tail1;
      2'd2:    tail_nxt = tail2;
      default: tail_nxt = tail_r;
    endcase
    head_nxt  = do_pop ? ((head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1)) : head_r;
    count_nxt = count_r + CW'(push.cnt) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[tail_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[tail1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

`include "serial_boot_loader_command_engine_unit_assert.svh"

  `SBLCE_ASSERT_SAME(a_no_overflow, push.cnt != 2'd0, room, "result pushed without room")
  `SBLCE_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "queue count out of range")

endmodule

`default_nettype wire

// ===== design/serial_boot_loader_command_engine_unit.sv =====
// Top level of the serial boot loader command engine: input byte register, parser, result queue.
// Depends on sblce_pkg, sblce_core, sblce_resq and the shared assertion macro header.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    in_rx_byte
//   out_     output     out_valid / out_stall  out_kind, out_tx_byte, out_target_address,
//                                              out_write_data, out_baud_value,
//                                              out_window_mask, out_last
//
// A received byte is captured in the input register on its transfer and parsed once the
// result queue has room for a result pair; its results are written into the result queue.
// One byte is taken per cycle while the result queue has room for a result pair; the queue
// drains one result per cycle while out_stall is low (window and goto bytes give two).
// The input stalls only while a held byte waits for room for two results in the queue.
// Reset is synchronous and active low; it returns the parser to idle and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module serial_boot_loader_command_engine_unit #(
  parameter int RESQ_DEPTH = sblce_pkg::RESQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_tx_byte,
  output logic [31:0]      out_target_address,
  output logic [7:0]       out_write_data,
  output logic [31:0]      out_baud_value,
  output logic [3:0]       out_window_mask,
  output logic             out_last
);

  // Input register: holds one received byte until the parser has consumed it.
  logic        full_r, full_nxt;
  logic [7:0]  byte_r;
  logic        in_xfer;
  logic        go;
  logic        room;

  sblce_pkg::push_t push;
  sblce_pkg::res_t  head;

  // The parser runs whenever a byte is held and the queue can absorb a result pair.
  assign go       = full_r && room;
  assign in_stall = full_r && !room;
  assign in_xfer  = in_valid && !in_stall;
  assign full_nxt = in_xfer ? 1'b1 : (go ? 1'b0 : full_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) byte_r <= in_rx_byte;
  end

  sblce_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .rx_byte (byte_r),
    .push    (push)
  );

  // The queue head is the output register; it only advances on an output transfer.
  sblce_resq #(
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (!out_stall),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign out_kind           = head.kind;
  assign out_tx_byte        = head.tx_byte;
  assign out_target_address = head.target_address;
  assign out_write_data     = head.write_data;
  assign out_baud_value     = head.baud_value;
  assign out_window_mask    = head.window_mask;
  assign out_last           = head.last;

`include "serial_boot_loader_command_engine_unit_assert.svh"

  `SBLCE_ASSERT_NEXT(a_byte_kept, in_stall, full_r && $stable(byte_r), "stalled byte lost")

endmodule

`default_nettype wire
